[sv/liang_barsky_line_clipper_unit_assert.svh]
`ifndef LIANG_BARSKY_LINE_CLIPPER_UNIT_ASSERT_SVH
`define LIANG_BARSKY_LINE_CLIPPER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define LBC_ASSERT_LAT(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

[sv/lbc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

    localparam int COORD_W   = 24;
    localparam int WIN_W     = 16;
    localparam int CFG_IDX_W = 4;

    localparam int COORD_FRAC_BITS_DEF = 8;
    localparam int PARAM_FRAC_BITS_DEF = 16;

    localparam logic signed [WIN_W-1:0] WIN_LEFT_RST   = 16'sd0;
    localparam logic signed [WIN_W-1:0] WIN_BOTTOM_RST = 16'sd0;
    localparam logic signed [WIN_W-1:0] WIN_RIGHT_RST  = 16'sd255;
    localparam logic signed [WIN_W-1:0] WIN_TOP_RST    = 16'sd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIN_LEFT   = 4'd0,
        REG_WIN_BOTTOM = 4'd1,
        REG_WIN_RIGHT  = 4'd2,
        REG_WIN_TOP    = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } seg_in_t;

    typedef struct packed {
        logic                      visible;
        logic signed [COORD_W-1:0] clip_start_x;
        logic signed [COORD_W-1:0] clip_start_y;
        logic signed [COORD_W-1:0] clip_end_x;
        logic signed [COORD_W-1:0] clip_end_y;
    } seg_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W:0]   dx;
        logic signed [COORD_W:0]   dy;
    } seg_geom_t;

    typedef struct packed {
        logic parallel;
        logic q_neg;
        logic p_neg;
        logic r_neg;
    } edge_flag_t;

    function automatic int q_width(input int cfb);
        int sw;
        sw = (WIN_W + cfb > COORD_W) ? WIN_W + cfb : COORD_W;
        return sw + 1;
    endfunction

    function automatic int div_width(input int cfb);
        int qw;
        qw = q_width(cfb);
        return ((qw > COORD_W + 3) ? qw : COORD_W + 3) + 1;
    endfunction

endpackage

`default_nettype wire

[sv/lbc_edge_setup.sv]
`timescale 1ns / 1ps
`default_nettype none

module lbc_edge_setup #(
    parameter int COORD_FRAC_BITS = lbc_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    input  lbc_pkg::seg_in_t                              segment,
    input  logic signed [lbc_pkg::WIN_W-1:0]              win_left,
    input  logic signed [lbc_pkg::WIN_W-1:0]              win_bottom,
    input  logic signed [lbc_pkg::WIN_W-1:0]              win_right,
    input  logic signed [lbc_pkg::WIN_W-1:0]              win_top,
    output logic                                          out_valid,
    output lbc_pkg::seg_geom_t                            geom,
    output logic [lbc_pkg::q_width(COORD_FRAC_BITS)-1:0]  aq [4],
    output logic [lbc_pkg::COORD_W:0]                     ap [4],
    output lbc_pkg::edge_flag_t                           flags [4]
);

    localparam int QW = lbc_pkg::q_width(COORD_FRAC_BITS);
    localparam int SW = QW - 1;
    localparam int DW = lbc_pkg::COORD_W + 1;

    logic signed [SW-1:0] wl_s, wb_s, wr_s, wt_s;

    lbc_pkg::seg_geom_t   geom_next;
    logic signed [QW-1:0] q_next [4];

    logic                 v1_reg;
    lbc_pkg::seg_geom_t   g1_reg;
    logic signed [QW-1:0] q_reg [4];

    logic                 v2_reg;
    lbc_pkg::seg_geom_t   g2_reg;
    logic [QW-1:0]        aq_next [4];
    logic [QW-1:0]        aq_reg [4];
    logic [DW-1:0]        ap_next [4];
    logic [DW-1:0]        ap_reg [4];
    lbc_pkg::edge_flag_t  flg_next [4];
    lbc_pkg::edge_flag_t  flg_reg [4];

    assign wl_s = SW'(win_left) <<< COORD_FRAC_BITS;
    assign wb_s = SW'(win_bottom) <<< COORD_FRAC_BITS;
    assign wr_s = SW'(win_right) <<< COORD_FRAC_BITS;
    assign wt_s = SW'(win_top) <<< COORD_FRAC_BITS;

    always_comb
    begin
        geom_next.sx = segment.start_x;
        geom_next.sy = segment.start_y;
        geom_next.dx = DW'(segment.end_x) - DW'(segment.start_x);
        geom_next.dy = DW'(segment.end_y) - DW'(segment.start_y);
        q_next[0]    = QW'(segment.start_x) - QW'(wl_s);
        q_next[1]    = QW'(wr_s) - QW'(segment.start_x);
        q_next[2]    = QW'(segment.start_y) - QW'(wb_s);
        q_next[3]    = QW'(wt_s) - QW'(segment.start_y);
    end

    always_comb
    begin
        logic signed [DW-1:0] pv [4];
        pv[0] = -g1_reg.dx;
        pv[1] = g1_reg.dx;
        pv[2] = -g1_reg.dy;
        pv[3] = g1_reg.dy;
        for (int i = 0; i < 4; i++)
        begin
            aq_next[i]           = q_reg[i][QW-1] ? QW'(-q_reg[i]) : QW'(q_reg[i]);
            ap_next[i]           = pv[i][DW-1] ? DW'(-pv[i]) : DW'(pv[i]);
            flg_next[i].parallel = (pv[i] == '0);
            flg_next[i].q_neg    = q_reg[i][QW-1];
            flg_next[i].p_neg    = pv[i][DW-1];
            flg_next[i].r_neg    = q_reg[i][QW-1] ^ pv[i][DW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        g1_reg  <= geom_next;
        q_reg   <= q_next;
        g2_reg  <= g1_reg;
        aq_reg  <= aq_next;
        ap_reg  <= ap_next;
        flg_reg <= flg_next;
    end

    assign out_valid = v2_reg;
    assign geom      = g2_reg;
    assign aq        = aq_reg;
    assign ap        = ap_reg;
    assign flags     = flg_reg;

endmodule

`default_nettype wire

[sv/lbc_div_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module lbc_div_lane #(
    parameter int COORD_FRAC_BITS = lbc_pkg::COORD_FRAC_BITS_DEF,
    parameter int PARAM_FRAC_BITS = lbc_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic [lbc_pkg::q_width(COORD_FRAC_BITS)-1:0]  aq,
    input  logic [lbc_pkg::COORD_W:0]                     ap,
    output logic [PARAM_FRAC_BITS+1:0]                    mag,
    output logic                                          sat
);

    localparam int DW  = lbc_pkg::div_width(COORD_FRAC_BITS);
    localparam int NST = PARAM_FRAC_BITS + 2;

    logic [DW-1:0]  num_x;
    logic [DW-1:0]  den_x;
    logic           top_bit;

    logic [DW-1:0]  rem_reg [NST];
    logic [DW-1:0]  den_reg [NST];
    logic [NST-1:0] quo_reg [NST];
    logic           sat_reg [NST];

    assign num_x   = DW'(aq);
    assign den_x   = DW'(ap);
    assign top_bit = (num_x >= (den_x << 1));

    // leading step weighs twice the divisor
    always_ff @(posedge clk)
    begin
        sat_reg[0] <= (num_x >= (den_x << 2));
        rem_reg[0] <= top_bit ? num_x - (den_x << 1) : num_x;
        den_reg[0] <= den_x;
        quo_reg[0] <= {top_bit, {(NST-1){1'b0}}};
    end

    for (genvar k = 1; k < NST; k++)
    begin : g_step
        logic          fit;
        logic [DW-1:0] diff;

        assign fit  = (rem_reg[k-1] >= den_reg[k-1]);
        assign diff = rem_reg[k-1] - den_reg[k-1];

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= (fit ? diff : rem_reg[k-1]) << 1;
            den_reg[k] <= den_reg[k-1];
            sat_reg[k] <= sat_reg[k-1];
            quo_reg[k] <= quo_reg[k-1] | (NST'(fit) << (NST - 1 - k));
        end
    end

    assign mag = quo_reg[NST-1];
    assign sat = sat_reg[NST-1];

endmodule

`default_nettype wire

[sv/lbc_param_select.sv]
`timescale 1ns / 1ps
`default_nettype none

module lbc_param_select #(
    parameter int PARAM_FRAC_BITS = lbc_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  lbc_pkg::seg_geom_t           geom_in,
    input  logic [PARAM_FRAC_BITS+1:0]   mag [4],
    input  logic                         sat [4],
    input  lbc_pkg::edge_flag_t          flags [4],
    output logic                         out_valid,
    output lbc_pkg::seg_geom_t           geom_out,
    output logic                         ok,
    output logic [PARAM_FRAC_BITS:0]     u0,
    output logic [PARAM_FRAC_BITS:0]     u1
);

    localparam int MW = PARAM_FRAC_BITS + 2;
    localparam int RW = PARAM_FRAC_BITS + 3;
    localparam int UW = PARAM_FRAC_BITS + 1;

    logic                 ok_next;
    logic signed [RW-1:0] u0_next;
    logic signed [RW-1:0] u1_next;

    logic                 vld_reg;
    lbc_pkg::seg_geom_t   geom_reg;
    logic                 ok_reg;
    logic [UW-1:0]        u0_reg;
    logic [UW-1:0]        u1_reg;

    always_comb
    begin
        logic signed [RW-1:0] r;
        ok_next = 1'b1;
        u0_next = '0;
        u1_next = RW'(1) <<< PARAM_FRAC_BITS;
        for (int i = 0; i < 4; i++)
        begin
            if (flags[i].r_neg && (mag[i] != '0))
                r = '1;
            else if (sat[i])
                r = RW'({MW{1'b1}});
            else
                r = RW'(mag[i]);

            if (flags[i].parallel)
            begin
                if (flags[i].q_neg)
                    ok_next = 1'b0;
            end
            else if (flags[i].p_neg)
            begin
                if (r > u1_next)
                    ok_next = 1'b0;
                else if (r > u0_next)
                    u0_next = r;
            end
            else
            begin
                if (r < u0_next)
                    ok_next = 1'b0;
                else if (r < u1_next)
                    u1_next = r;
            end
        end
        if (u0_next > u1_next)
            ok_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        geom_reg <= geom_in;
        ok_reg   <= ok_next;
        u0_reg   <= UW'(u0_next);
        u1_reg   <= UW'(u1_next);
    end

    assign out_valid = vld_reg;
    assign geom_out  = geom_reg;
    assign ok        = ok_reg;
    assign u0        = u0_reg;
    assign u1        = u1_reg;

endmodule

`default_nettype wire

[sv/lbc_interp.sv]
`timescale 1ns / 1ps
`default_nettype none

module lbc_interp #(
    parameter int PARAM_FRAC_BITS = lbc_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  lbc_pkg::seg_geom_t       geom,
    input  logic                     ok,
    input  logic [PARAM_FRAC_BITS:0] u0,
    input  logic [PARAM_FRAC_BITS:0] u1,
    output logic                     done,
    output lbc_pkg::seg_out_t        result
);

    localparam int CW  = lbc_pkg::COORD_W;
    localparam int UW  = PARAM_FRAC_BITS + 1;
    localparam int PRW = CW + 1 + UW + 1;
    localparam logic signed [PRW-1:0] Half = PRW'(1) <<< (PARAM_FRAC_BITS - 1);

    logic signed [PRW-1:0] su0;
    logic signed [PRW-1:0] su1;
    logic signed [PRW-1:0] prod_next [4];

    logic                  v1_reg;
    logic                  ok1_reg;
    logic signed [CW-1:0]  sx_reg;
    logic signed [CW-1:0]  sy_reg;
    logic signed [PRW-1:0] prod_reg [4];

    lbc_pkg::seg_out_t     res_next;
    lbc_pkg::seg_out_t     res_reg;
    logic                  done_reg;

    assign su0 = PRW'(signed'({1'b0, u0}));
    assign su1 = PRW'(signed'({1'b0, u1}));

    always_comb
    begin
        prod_next[0] = PRW'(geom.dx) * su0;
        prod_next[1] = PRW'(geom.dy) * su0;
        prod_next[2] = PRW'(geom.dx) * su1;
        prod_next[3] = PRW'(geom.dy) * su1;
    end

    always_comb
    begin
        logic signed [PRW-1:0] pt [4];
        for (int i = 0; i < 4; i++)
            pt[i] = ((prod_reg[i] + Half) >>> PARAM_FRAC_BITS)
                  + PRW'(((i % 2) == 0) ? sx_reg : sy_reg);
        res_next.visible      = ok1_reg;
        res_next.clip_start_x = ok1_reg ? CW'(pt[0]) : '0;
        res_next.clip_start_y = ok1_reg ? CW'(pt[1]) : '0;
        res_next.clip_end_x   = ok1_reg ? CW'(pt[2]) : '0;
        res_next.clip_end_y   = ok1_reg ? CW'(pt[3]) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok1_reg  <= ok;
        sx_reg   <= geom.sx;
        sy_reg   <= geom.sy;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

[sv/liang_barsky_line_clipper_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "liang_barsky_line_clipper_unit_assert.svh"

// Line segment clipper against an axis-aligned window.
// Command side: drive segment and raise start; the item is taken on any edge
// where start is high and busy is low. busy is low at all times after the first
// cycle out of reset, so one segment can be taken on every clock.
// Result side: done is high for one cycle with result; the receiver cannot hold
// it off. visible low means the segment was rejected and all coordinates are 0.
// A segment passes through edge setup, the four ratio dividers (one quotient bit
// per stage), parameter select and the interpolation multiply stages.
// Throughput: one segment per clock.
// Window registers sit on the cfg channel (cfg_ready is always high); index 0
// left, 1 bottom, 2 right, 3 top, others ignored. Write only while no segment
// is in flight.
// Reset: window returns to [0, 255] x [0, 255], in-flight items are dropped and
// busy is high for one cycle.

module liang_barsky_line_clipper_unit #(
    parameter int COORD_FRAC_BITS = lbc_pkg::COORD_FRAC_BITS_DEF,
    parameter int PARAM_FRAC_BITS = lbc_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  lbc_pkg::seg_in_t                 segment,
    output logic                             done,
    output lbc_pkg::seg_out_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbc_pkg::WIN_W-1:0]        cfg_data
);

    localparam int QW      = lbc_pkg::q_width(COORD_FRAC_BITS);
    localparam int NST     = PARAM_FRAC_BITS + 2;
    localparam int Latency = PARAM_FRAC_BITS + 7;

    logic                              busy_reg;
    logic signed [lbc_pkg::WIN_W-1:0]  win_left_reg;
    logic signed [lbc_pkg::WIN_W-1:0]  win_bottom_reg;
    logic signed [lbc_pkg::WIN_W-1:0]  win_right_reg;
    logic signed [lbc_pkg::WIN_W-1:0]  win_top_reg;

    logic                              su_valid;
    lbc_pkg::seg_geom_t                su_geom;
    logic [QW-1:0]                     su_aq [4];
    logic [lbc_pkg::COORD_W:0]         su_ap [4];
    lbc_pkg::edge_flag_t               su_flags [4];

    logic [PARAM_FRAC_BITS+1:0]        dv_mag [4];
    logic                              dv_sat [4];

    logic [NST-1:0]                    vld_pipe_reg;
    lbc_pkg::seg_geom_t                geom_pipe_reg [NST];
    lbc_pkg::edge_flag_t               flg_pipe_reg [NST][4];

    logic                              ps_valid;
    lbc_pkg::seg_geom_t                ps_geom;
    logic                              ps_ok;
    logic [PARAM_FRAC_BITS:0]          ps_u0;
    logic [PARAM_FRAC_BITS:0]          ps_u1;

    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            win_left_reg   <= lbc_pkg::WIN_LEFT_RST;
            win_bottom_reg <= lbc_pkg::WIN_BOTTOM_RST;
            win_right_reg  <= lbc_pkg::WIN_RIGHT_RST;
            win_top_reg    <= lbc_pkg::WIN_TOP_RST;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    lbc_pkg::REG_WIN_LEFT:   win_left_reg   <= cfg_data;
                    lbc_pkg::REG_WIN_BOTTOM: win_bottom_reg <= cfg_data;
                    lbc_pkg::REG_WIN_RIGHT:  win_right_reg  <= cfg_data;
                    lbc_pkg::REG_WIN_TOP:    win_top_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    lbc_edge_setup #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy_reg),
        .segment    (segment),
        .win_left   (win_left_reg),
        .win_bottom (win_bottom_reg),
        .win_right  (win_right_reg),
        .win_top    (win_top_reg),
        .out_valid  (su_valid),
        .geom       (su_geom),
        .aq         (su_aq),
        .ap         (su_ap),
        .flags      (su_flags)
    );

    for (genvar e = 0; e < 4; e++)
    begin : g_div
        lbc_div_lane #(
            .COORD_FRAC_BITS (COORD_FRAC_BITS),
            .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
        ) u_div (
            .clk (clk),
            .aq  (su_aq[e]),
            .ap  (su_ap[e]),
            .mag (dv_mag[e]),
            .sat (dv_sat[e])
        );
    end

    // carry the segment alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_pipe_reg <= '0;
        else
            vld_pipe_reg <= {vld_pipe_reg[NST-2:0], su_valid};
    end

    always_ff @(posedge clk)
    begin
        geom_pipe_reg[0] <= su_geom;
        flg_pipe_reg[0]  <= su_flags;
        for (int j = 1; j < NST; j++)
        begin
            geom_pipe_reg[j] <= geom_pipe_reg[j-1];
            flg_pipe_reg[j]  <= flg_pipe_reg[j-1];
        end
    end

    lbc_param_select #(
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_pipe_reg[NST-1]),
        .geom_in   (geom_pipe_reg[NST-1]),
        .mag       (dv_mag),
        .sat       (dv_sat),
        .flags     (flg_pipe_reg[NST-1]),
        .out_valid (ps_valid),
        .geom_out  (ps_geom),
        .ok        (ps_ok),
        .u0        (ps_u0),
        .u1        (ps_u1)
    );

    lbc_interp #(
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ps_valid),
        .geom     (ps_geom),
        .ok       (ps_ok),
        .u0       (ps_u0),
        .u1       (ps_u1),
        .done     (done),
        .result   (result)
    );

    `LBC_ASSERT_LAT(a_latency, start && !busy, Latency, done, "accepted item gave no result")
    `LBC_ASSERT_IMP(a_reject_zero, done && !result.visible, (result.clip_start_x == '0) && (result.clip_start_y == '0) && (result.clip_end_x == '0) && (result.clip_end_y == '0), "rejected item has coordinates")

endmodule

`default_nettype wire
